>>> hdl/bnbc_pkg.sv
package bnbc_pkg;

  localparam int WORD_BITS = 8;

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

>>> hdl/bnbc_word_if.sv
interface bnbc_word_if;

  logic               valid;
  logic               ready;
  logic               func;
  bnbc_pkg::word_t    word;
  logic               label;
  logic               last;

  modport source (output valid, output func, output word, output label, output last,
                  input ready);
  modport sink (input valid, input func, input word, input label, input last,
                output ready);

endinterface

>>> hdl/bnbc_result_if.sv
interface bnbc_result_if;

  logic valid;
  logic ready;
  logic predicted_class;
  logic untrained;

  modport source (output valid, output predicted_class, output untrained, input ready);
  modport sink (input valid, input predicted_class, input untrained, output ready);

endinterface

>>> hdl/bnbc_log2.sv
module bnbc_log2 #(
  parameter int XW        = 17,
  parameter int FRAC_BITS = 8,
  parameter int YW        = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] x,
  output logic          done,
  output logic [YW-1:0] y
);

  localparam int SB = $clog2(XW);
  localparam int CW = $clog2(SB + FRAC_BITS + 1);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_LOAD = 2'd2;
  localparam logic [1:0] L_SQ   = 2'd3;

  logic [1:0]           state;
  logic [CW-1:0]        step;
  logic [XW-1:0]        xn;
  logic [SB-1:0]        sh;
  logic [SB-1:0]        e;
  logic [31:0]          m;
  logic [FRAC_BITS-1:0] frac;

  logic [SB-1:0]        amt;
  logic                 top_zero;
  logic [63:0]          prod;
  logic [32:0]          q;
  logic [XW+31:0]       wide;

  always_comb begin
    amt      = SB'(1) << (CW'(SB - 1) - step);
    top_zero = ((xn >> (XW'(XW) - XW'(amt))) == '0);
    prod     = 64'(m) * 64'(m);
    q        = prod[63:31];
    wide     = {xn, 32'b0};
  end

  assign y = {e, frac};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= L_IDLE;
      step  <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            xn    <= x;
            sh    <= '0;
            step  <= '0;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (top_zero) begin
            xn <= xn << amt;
            sh <= sh + amt;
          end
          if (step == CW'(SB - 1)) begin
            step  <= '0;
            state <= L_LOAD;
          end else begin
            step <= step + CW'(1);
          end
        end
        L_LOAD: begin
          m     <= wide[XW+31 -: 32];
          e     <= SB'(XW - 1) - sh;
          state <= L_SQ;
        end
        L_SQ: begin
          frac <= {frac[FRAC_BITS-2:0], q[32]};
          m    <= q[32] ? q[32:1] : q[31:0];
          if (step == CW'(FRAC_BITS - 1)) begin
            done  <= 1'b1;
            state <= L_IDLE;
          end else begin
            step <= step + CW'(1);
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/bernoulli_naive_bayes_classifier_unit.sv
// Two-class Bernoulli naive Bayes classifier. Words transfer one per cycle and
// set a bit in the presence memory. After reset a clearing pass zeroes the
// presence and count memories before the first word is taken. The word that
// ends a training document starts a walk over the vocabulary, a read state
// and a write state per entry, that updates the counts through one read and
// one write port. The word that ends a document to classify starts a walk
// driven by the shared iterative log2 unit: up to three logarithms for the
// priors, then up to two per vocabulary entry. An untrained classifier
// answers without a walk and then runs a clearing pass. Input is stalled
// during each walk and each clearing pass.
module bernoulli_naive_bayes_classifier_unit #(
  parameter int VOCAB_SIZE    = 256,
  parameter int COUNT_BITS    = 16,
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  bnbc_word_if.sink    words,
  bnbc_result_if.source results
);

  localparam int IW = $clog2(VOCAB_SIZE);
  localparam int CB = COUNT_BITS;
  localparam int XW = COUNT_BITS + 1;
  localparam int YW = $clog2(XW) + LOG_FRAC_BITS;
  localparam int SW = $clog2(VOCAB_SIZE + 1) + $clog2(COUNT_BITS + 2) + LOG_FRAC_BITS + 2;
  localparam logic signed [SW-1:0] FLOOR = SW'(-((COUNT_BITS + 1) << LOG_FRAC_BITS));
  localparam logic [CB-1:0] CMAX = '1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_TRD   = 4'd2;
  localparam logic [3:0] ST_TWR   = 4'd3;
  localparam logic [3:0] ST_LTOT  = 4'd4;
  localparam logic [3:0] ST_LN0   = 4'd5;
  localparam logic [3:0] ST_LN1   = 4'd6;
  localparam logic [3:0] ST_PRIOR = 4'd7;
  localparam logic [3:0] ST_CRD   = 4'd8;
  localparam logic [3:0] ST_CDATA = 4'd9;
  localparam logic [3:0] ST_W0    = 4'd10;
  localparam logic [3:0] ST_W1    = 4'd11;
  localparam logic [3:0] ST_CWR   = 4'd12;
  localparam logic [3:0] ST_RES   = 4'd13;

  logic [0:0]       pres_mem [VOCAB_SIZE];
  logic [2*CB-1:0]  cnt_mem  [VOCAB_SIZE];

  logic [3:0]       state;
  logic [IW-1:0]    addr;
  logic             label;
  logic [CB-1:0]    d0, d1;
  logic [0:0]       rd_pres;
  logic [2*CB-1:0]  rd_row;
  logic [CB-1:0]    num0, num1;
  logic signed [SW-1:0] ltot, l0, l1, s0, s1;
  logic             pend;
  logic             untr;
  logic             out_valid, out_class, out_untr;

  logic             accept, in_range, addr_last;
  logic [IW-1:0]    idx;
  logic [XW-1:0]    total;
  logic [CB-1:0]    c0, c1;
  logic             pres_we, cnt_we;
  logic [IW-1:0]    pres_wa;
  logic [0:0]       pres_wd;
  logic [2*CB-1:0]  cnt_wd;
  logic             lg_start, lg_done;
  logic [XW-1:0]    lg_x;
  logic [YW-1:0]    lg_y;
  logic signed [SW-1:0] lg_ext;

  bnbc_log2 #(.XW(XW), .FRAC_BITS(LOG_FRAC_BITS), .YW(YW)) u_log2 (
    .clk(clk), .rst(rst), .start(lg_start), .x(lg_x), .done(lg_done), .y(lg_y)
  );

  assign words.ready             = (state == ST_IDLE);
  assign results.valid           = out_valid;
  assign results.predicted_class = out_class;
  assign results.untrained       = out_untr;

  always_comb begin
    accept    = words.valid && (state == ST_IDLE);
    in_range  = ({24'd0, words.word} < VOCAB_SIZE);
    idx       = IW'({24'd0, words.word});
    addr_last = (addr == IW'(VOCAB_SIZE - 1));
    total     = {1'b0, d0} + {1'b0, d1};
    c0        = rd_row[CB-1:0];
    c1        = rd_row[2*CB-1:CB];
    lg_ext    = signed'(SW'(lg_y));

    pres_we = 1'b0;
    pres_wa = addr;
    pres_wd = 1'b0;
    cnt_we  = 1'b0;
    cnt_wd  = '0;
    case (state)
      ST_CLEAR: begin
        pres_we = 1'b1;
        cnt_we  = 1'b1;
      end
      ST_IDLE: begin
        pres_we = accept && in_range;
        pres_wa = idx;
        pres_wd = 1'b1;
      end
      ST_TWR: begin
        pres_we = 1'b1;
        cnt_we  = rd_pres[0];
        if (label) begin
          cnt_wd = {(c1 == CMAX) ? c1 : c1 + CB'(1), c0};
        end else begin
          cnt_wd = {c1, (c0 == CMAX) ? c0 : c0 + CB'(1)};
        end
      end
      ST_CWR: pres_we = 1'b1;
      default: ;
    endcase

    lg_start = 1'b0;
    lg_x     = '0;
    case (state)
      ST_LTOT: begin
        lg_start = !pend;
        lg_x     = total;
      end
      ST_LN0: begin
        lg_start = !pend && (d0 != '0);
        lg_x     = XW'(d0);
      end
      ST_LN1: begin
        lg_start = !pend && (d1 != '0);
        lg_x     = XW'(d1);
      end
      ST_W0: begin
        lg_start = !pend && (d0 != '0) && (num0 != '0);
        lg_x     = XW'(num0);
      end
      ST_W1: begin
        lg_start = !pend && (d1 != '0) && (num1 != '0);
        lg_x     = XW'(num1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_wa] <= pres_wd;
    end
    if (cnt_we) begin
      cnt_mem[addr] <= cnt_wd;
    end
    rd_pres <= pres_mem[addr];
    rd_row  <= cnt_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      addr      <= '0;
      d0        <= '0;
      d1        <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (lg_start) begin
        pend <= 1'b1;
      end
      case (state)
        ST_CLEAR: begin
          addr <= addr + IW'(1);
          if (addr_last) begin
            addr  <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && words.last) begin
            label <= words.label;
            addr  <= '0;
            if (!words.func) begin
              state <= ST_TRD;
            end else if (total == '0) begin
              untr  <= 1'b1;
              state <= ST_RES;
            end else begin
              untr  <= 1'b0;
              state <= ST_LTOT;
            end
          end
        end
        ST_TRD: state <= ST_TWR;
        ST_TWR: begin
          if (addr_last) begin
            addr <= '0;
            if (label) begin
              d1 <= (d1 == CMAX) ? d1 : d1 + CB'(1);
            end else begin
              d0 <= (d0 == CMAX) ? d0 : d0 + CB'(1);
            end
            state <= ST_IDLE;
          end else begin
            addr  <= addr + IW'(1);
            state <= ST_TRD;
          end
        end
        ST_LTOT: begin
          if (lg_done) begin
            ltot  <= lg_ext;
            pend  <= 1'b0;
            state <= ST_LN0;
          end
        end
        ST_LN0: begin
          if (d0 == '0) begin
            state <= ST_LN1;
          end else if (lg_done) begin
            l0    <= lg_ext;
            pend  <= 1'b0;
            state <= ST_LN1;
          end
        end
        ST_LN1: begin
          if (d1 == '0) begin
            state <= ST_PRIOR;
          end else if (lg_done) begin
            l1    <= lg_ext;
            pend  <= 1'b0;
            state <= ST_PRIOR;
          end
        end
        ST_PRIOR: begin
          s0    <= (d0 == '0) ? FLOOR : l0 - ltot;
          s1    <= (d1 == '0) ? FLOOR : l1 - ltot;
          state <= ST_CRD;
        end
        ST_CRD: state <= ST_CDATA;
        ST_CDATA: begin
          num0  <= rd_pres[0] ? c0 : ((d0 >= c0) ? d0 - c0 : '0);
          num1  <= rd_pres[0] ? c1 : ((d1 >= c1) ? d1 - c1 : '0);
          state <= ST_W0;
        end
        ST_W0: begin
          if ((d0 == '0) || (num0 == '0)) begin
            s0    <= s0 + FLOOR;
            state <= ST_W1;
          end else if (lg_done) begin
            s0    <= s0 + (lg_ext - l0);
            pend  <= 1'b0;
            state <= ST_W1;
          end
        end
        ST_W1: begin
          if ((d1 == '0) || (num1 == '0)) begin
            s1    <= s1 + FLOOR;
            state <= ST_CWR;
          end else if (lg_done) begin
            s1    <= s1 + (lg_ext - l1);
            pend  <= 1'b0;
            state <= ST_CWR;
          end
        end
        ST_CWR: begin
          if (addr_last) begin
            addr  <= '0;
            state <= ST_RES;
          end else begin
            addr  <= addr + IW'(1);
            state <= ST_CRD;
          end
        end
        ST_RES: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_untr  <= untr;
            out_class <= untr ? 1'b1 : !(s0 > s1);
            state     <= untr ? ST_CLEAR : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> verif/testbench.sv
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOCAB = 256;
  localparam int CNT_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam longint LOG_FLOOR = -(longint'(CNT_BITS + 1) <<< FRAC_BITS);
  localparam int unsigned CNT_MAX = (1 << CNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 30000000;
  localparam int DRAIN_CYCLES = 12000;

  localparam bit FUNC_TRAIN = 1'b0;
  localparam bit FUNC_CLASSIFY = 1'b1;

  typedef struct {
    bit              func;
    bnbc_pkg::word_t word;
    bit              label;
    bit              last;
    bit              pause;
  } word_item_t;

  typedef struct {
    bit predicted_class;
    bit untrained;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bnbc_word_if   words_bus();
  bnbc_result_if result_bus();

  bernoulli_naive_bayes_classifier_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .words   (words_bus),
    .results (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  word_item_t  word_q[$];
  verdict_t    verdict_q[$];
  int          items_sent = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  bit          word_taken = 1'b0;

  bit          seen[VOCAB];
  int unsigned word_count[2][VOCAB];
  int unsigned doc_count[2];

  function automatic longint log2_fixed(longint unsigned x);
    int unsigned e;
    longint unsigned t;
    longint unsigned m;
    longint unsigned frac;
    e = 0;
    t = x;
    frac = 0;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return longint'((longint'(e) << FRAC_BITS) | frac);
  endfunction

  function automatic longint log_ratio(longint unsigned num, longint unsigned den);
    if (num == 0 || den == 0) return LOG_FLOOR;
    return log2_fixed(num) - log2_fixed(den);
  endfunction

  function automatic longint class_log_score(int c, longint unsigned total);
    longint unsigned nc;
    longint unsigned cnt;
    longint s;
    nc = doc_count[c];
    s = log_ratio(nc, total);
    for (int w = 0; w < VOCAB; w++) begin
      cnt = word_count[c][w];
      if (seen[w]) s += log_ratio(cnt, nc);
      else s += log_ratio((nc >= cnt) ? nc - cnt : 0, nc);
    end
    return s;
  endfunction

  function automatic void absorb_word(word_item_t it);
    longint unsigned total;
    verdict_t v;
    seen[it.word] = 1'b1;
    if (!it.last) return;
    if (it.func == FUNC_TRAIN) begin
      for (int w = 0; w < VOCAB; w++)
        if (seen[w] && word_count[it.label][w] < CNT_MAX) word_count[it.label][w]++;
      if (doc_count[it.label] < CNT_MAX) doc_count[it.label]++;
    end else begin
      total = longint'(doc_count[0]) + longint'(doc_count[1]);
      if (total == 0) begin
        v.predicted_class = 1'b1;
        v.untrained = 1'b1;
      end else begin
        v.predicted_class =
          (class_log_score(0, total) > class_log_score(1, total)) ? 1'b0 : 1'b1;
        v.untrained = 1'b0;
      end
      verdict_q = {verdict_q, v};
    end
    foreach (seen[w]) seen[w] = 1'b0;
  endfunction

  always @(posedge clk) begin
    word_item_t it;
    verdict_t   exp_v;
    cycle_count <= cycle_count + 1;
    word_taken <= !rst && words_bus.valid && words_bus.ready;
    if (!rst && words_bus.valid && words_bus.ready) begin
      it.func = words_bus.func;
      it.word = words_bus.word;
      it.label = words_bus.label;
      it.last = words_bus.last;
      it.pause = 1'b0;
      absorb_word(it);
    end
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (verdict_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("Unexpected result transfer: class %0d untrained %0d",
                                        result_bus.predicted_class, result_bus.untrained);
      end else begin
        exp_v = verdict_q.pop_front();
        if (result_bus.predicted_class !== exp_v.predicted_class ||
            result_bus.untrained !== exp_v.untrained) begin
          error_count++;
          if (error_count <= 10)
            $display({"Result mismatch: expected class %0d untrained %0d, ",
                      "got class %0d untrained %0d"},
                     exp_v.predicted_class, exp_v.untrained,
                     result_bus.predicted_class, result_bus.untrained);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    words_bus.valid = 1'b0;
    words_bus.func = 1'b0;
    words_bus.word = '0;
    words_bus.label = 1'b0;
    words_bus.last = 1'b0;
    result_bus.ready = 1'b0;
  end

  always @(negedge clk) begin
    word_item_t it;
    bit calm;
    calm = items_sent >= 300 && items_sent < 450;
    if (rst) begin
      words_bus.valid <= 1'b0;
      result_bus.ready <= 1'b0;
    end else begin
      if (!words_bus.valid || word_taken) begin
        if (word_q.size() > 0 && (!word_q[0].pause || verdict_q.size() == 0) &&
            (calm || $urandom_range(0, 99) >= 13)) begin
          it = word_q.pop_front();
          words_bus.valid <= 1'b1;
          words_bus.func <= it.func;
          words_bus.word <= it.word;
          words_bus.label <= it.label;
          words_bus.last <= it.last;
          items_sent++;
        end else begin
          words_bus.valid <= 1'b0;
        end
      end
      result_bus.ready <= calm || $urandom_range(0, 99) >= 13;
    end
  end

  task automatic add_doc(bit func, bit label, int wl[], bit mixed = 1'b0, bit pause = 1'b0);
    word_item_t it;
    foreach (wl[i]) begin
      it.last = (i == wl.size() - 1);
      it.func = (mixed && !it.last) ? bit'($urandom_range(0, 1)) : func;
      it.label = (mixed && !it.last) ? bit'($urandom_range(0, 1)) : label;
      it.word = bnbc_pkg::word_t'(wl[i]);
      it.pause = pause && i == 0;
      word_q = {word_q, it};
    end
  endtask

  initial begin
    int wl[];
    int n;
    int total;
    bit f;
    foreach (seen[w]) seen[w] = 1'b0;
    foreach (word_count[c, w]) word_count[c][w] = 0;
    doc_count[0] = 0;
    doc_count[1] = 0;

    add_doc(FUNC_CLASSIFY, 1'b0, '{0, 255});
    add_doc(FUNC_TRAIN, 1'b0, '{10});
    add_doc(FUNC_TRAIN, 1'b1, '{10});
    add_doc(FUNC_CLASSIFY, 1'b1, '{10});
    add_doc(FUNC_TRAIN, 1'b0, '{1, 2, 3, 1, 0});
    add_doc(FUNC_TRAIN, 1'b1, '{4, 5, 255, 5});
    add_doc(FUNC_CLASSIFY, 1'b0, '{1, 2});
    add_doc(FUNC_CLASSIFY, 1'b1, '{4, 5, 170});
    add_doc(FUNC_TRAIN, 1'b1, '{85, 4, 1}, 1'b1);
    add_doc(FUNC_CLASSIFY, 1'b0, '{255}, 1'b1, 1'b1);

    total = 0;
    while (total < 800) begin
      n = $urandom_range(1, 20);
      wl = new[n];
      foreach (wl[i]) wl[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 15);
      f = ($urandom_range(0, 99) < 40) ? FUNC_CLASSIFY : FUNC_TRAIN;
      add_doc(f, bit'($urandom_range(0, 1)), wl, $urandom_range(0, 9) == 0,
              $urandom_range(0, 49) == 0);
      total += n;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (word_q.size() == 0 && !words_bus.valid);
    wait (verdict_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/bnbc_pkg.sv
hdl/bnbc_word_if.sv
hdl/bnbc_result_if.sv
hdl/bnbc_log2.sv
hdl/bernoulli_naive_bayes_classifier_unit.sv
verif/testbench.sv
